### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the dotted identifier validator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked assertion, disabled while the active-low reset is asserted.
`define DOTID_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked assertion with no reset qualifier.
`define DOTID_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DOTID_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define DOTID_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

### design/dotid_pkg.sv
// ----------------------------------------------------------------------------
// Dotted identifier validator package
// Shared types and constants for the validator and its submodules.
// ----------------------------------------------------------------------------
package dotid_pkg;

  localparam int MAX_BYTES_W = 10;
  localparam int MAX_SEGS_W  = 4;
  localparam int DETAIL_W    = 12;
  localparam int SEG_CNT_W   = 5;

  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RST = 10'd128;
  localparam logic [MAX_SEGS_W-1:0]  MAX_SEGS_RST  = 4'd8;
  localparam logic [DETAIL_W-1:0]    DETAIL_MAX    = 12'hFFF;

  // Request kinds on the input channel.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Register indexes on the configuration port (taken from paddr[2]).
  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic REG_MAX_SEGS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK                = 3'd0,
    ST_EMPTY_SEGMENT     = 3'd1,
    ST_TOO_LONG          = 3'd2,
    ST_BAD_CHARACTER     = 3'd3,
    ST_TOO_MANY_SEGMENTS = 3'd4,
    ST_NOT_NAMESPACED    = 3'd5
  } status_e;

  typedef struct packed {
    logic [MAX_BYTES_W-1:0] max_bytes;
    logic [MAX_SEGS_W-1:0]  max_segments;
  } cfg_t;

  typedef struct packed {
    status_e               status;
    logic [DETAIL_W-1:0]   detail;
  } result_t;

endpackage

### design/dotid_if.sv
// ----------------------------------------------------------------------------
// Dotted identifier validator channels
// Valid/ready channel interfaces for identifier requests and status results.
// ----------------------------------------------------------------------------
interface dotid_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] character;

  modport source (output valid, action, character, input ready);
  modport sink   (input valid, action, character, output ready);
endinterface

interface dotid_out_if;
  logic                          valid;
  logic                          ready;
  dotid_pkg::status_e            status;
  logic [dotid_pkg::DETAIL_W-1:0] detail;

  modport source (output valid, status, detail, input ready);
  modport sink   (input valid, status, detail, output ready);
endinterface

### design/dotted_identifier_validator.sv
// ----------------------------------------------------------------------------
// Dotted identifier validator
// Streams a dot-separated identifier byte by byte and reports one status.
// ----------------------------------------------------------------------------
// The block checks an identifier that arrives as one request per byte,
// followed by an end request. Each dot-separated segment must start with a
// lowercase letter and continue with lowercase letters, digits or underscore;
// at least two segments and at most max_segments are allowed, and the whole
// name may hold at most max_bytes bytes. Byte requests produce no result; the
// end request produces exactly one status with its detail (the position of
// the first error, the byte count for an overlong name, or the segment count),
// after which the block is ready for the next identifier. The first error in
// stream order is kept, except that an overlong name is always reported as
// too long. Byte and segment counters saturate. Every request is held in
// the input register and checked there combinationally by the
// scanner, so one request is accepted per clock; an end request waits in the
// input register only while the result register still holds an untaken
// status. Byte requests keep flowing while a status waits on the output.
// The limits are written through the APB port at byte addresses 0 and 4 and
// should only be changed while no identifier is in flight.
// ----------------------------------------------------------------------------
module dotted_identifier_validator #(
  parameter int COUNT_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dotid_in_if.sink           in_i,
  dotid_out_if.source        out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dotid_pkg::*;

  cfg_t    cfg;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_data;

  // Limit registers.
  dotid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register plus the per-byte check and the stream state.
  dotid_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_action_i (in_i.action),
    .in_char_i   (in_i.character),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The result register decouples the output handshake from the scanner.
  dotid_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_data)
  );

  assign out_o.status = out_data.status;
  assign out_o.detail = out_data.detail;

endmodule

### design/dotid_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the byte and segment limits.
// ----------------------------------------------------------------------------
module dotid_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dotid_pkg::cfg_t     cfg_o
);
  import dotid_pkg::*;

  logic [MAX_BYTES_W-1:0] max_bytes_q, max_bytes_d;
  logic [MAX_SEGS_W-1:0]  max_segs_q, max_segs_d;
  logic                   wr_en;
  logic                   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    max_bytes_d = max_bytes_q;
    max_segs_d  = max_segs_q;
    if (wr_en) begin
      case (reg_sel)
        REG_MAX_BYTES: max_bytes_d = pwdata[MAX_BYTES_W-1:0];
        REG_MAX_SEGS:  max_segs_d  = pwdata[MAX_SEGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_BYTES: prdata = 32'(max_bytes_q);
      REG_MAX_SEGS:  prdata = 32'(max_segs_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RST;
      max_segs_q  <= MAX_SEGS_RST;
    end else begin
      max_bytes_q <= max_bytes_d;
      max_segs_q  <= max_segs_d;
    end
  end

  assign cfg_o.max_bytes    = max_bytes_q;
  assign cfg_o.max_segments = max_segs_q;

endmodule

### design/dotid_scan.sv
// ----------------------------------------------------------------------------
// Identifier scanner
// Input register, per-stream state and the single-pass check of each request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dotid_scan #(
  parameter int COUNT_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dotid_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_action_i,
  input  logic [7:0]           in_char_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output dotid_pkg::result_t   res_o
);
  import dotid_pkg::*;

  localparam int CW = (COUNT_BITS > MAX_BYTES_W) ? COUNT_BITS : MAX_BYTES_W;
  localparam int DW = (COUNT_BITS > DETAIL_W) ? COUNT_BITS : DETAIL_W;
  localparam logic [DW-1:0] DETAIL_CAP = DW'(DETAIL_MAX);

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return is_lower(c) || ((c >= CH_DIG_0) && (c <= CH_DIG_9)) || (c == CH_UNDER);
  endfunction

  // Input register.
  logic                  item_valid_q;
  logic                  action_q;
  logic [7:0]            char_q;
  logic                  advance;

  // Stream state.
  logic [COUNT_BITS-1:0] byte_cnt_q, byte_cnt_d;
  logic [SEG_CNT_W-1:0]  seg_cnt_q, seg_cnt_d;
  logic                  at_start_q, at_start_d;
  logic                  err_seen_q, err_seen_d;
  status_e               err_code_q, err_code_d;
  logic [COUNT_BITS-1:0] err_detail_q, err_detail_d;
  logic [COUNT_BITS-1:0] seg_begin_q, seg_begin_d;

  logic [COUNT_BITS-1:0] byte_inc;
  logic [SEG_CNT_W-1:0]  seg_inc;
  logic                  seg_over;
  logic                  too_long;
  status_e               status;
  logic [DW-1:0]         detail_full;

  assign advance     = item_valid_q && ((action_q == ACT_BYTE) || res_ready_i);
  assign in_ready_o  = !item_valid_q || advance;
  assign res_valid_o = item_valid_q && (action_q == ACT_END);

  assign byte_inc = (byte_cnt_q == '1) ? byte_cnt_q : byte_cnt_q + 1'b1;
  assign seg_inc  = (seg_cnt_q == '1) ? seg_cnt_q : seg_cnt_q + 1'b1;
  assign seg_over = seg_inc > SEG_CNT_W'(cfg_i.max_segments);
  assign too_long = CW'(byte_cnt_q) > CW'(cfg_i.max_bytes);

  always_comb begin
    byte_cnt_d   = byte_cnt_q;
    seg_cnt_d    = seg_cnt_q;
    at_start_d   = at_start_q;
    err_seen_d   = err_seen_q;
    err_code_d   = err_code_q;
    err_detail_d = err_detail_q;
    seg_begin_d  = seg_begin_q;
    status       = ST_OK;
    detail_full  = '0;

    if (action_q == ACT_BYTE) begin
      byte_cnt_d = byte_inc;
      if (char_q == CH_DOT) begin
        if (!err_seen_q) begin
          if (at_start_q) begin
            err_seen_d   = 1'b1;
            err_code_d   = ST_EMPTY_SEGMENT;
            err_detail_d = seg_begin_q;
          end else begin
            seg_cnt_d = seg_inc;
            if (seg_over) begin
              err_seen_d   = 1'b1;
              err_code_d   = ST_TOO_MANY_SEGMENTS;
              err_detail_d = COUNT_BITS'(seg_inc);
            end
          end
        end
        at_start_d  = 1'b1;
        seg_begin_d = byte_inc;
      end else begin
        if (!err_seen_q && (at_start_q ? !is_lower(char_q) : !is_body(char_q))) begin
          err_seen_d   = 1'b1;
          err_code_d   = ST_BAD_CHARACTER;
          err_detail_d = byte_cnt_q;
        end
        at_start_d = 1'b0;
      end
    end else begin
      // End of identifier: the closing segment is checked here, then the
      // stream state returns to its start values.
      if (byte_cnt_q == '0) begin
        status = ST_EMPTY_SEGMENT;
      end else if (too_long) begin
        status      = ST_TOO_LONG;
        detail_full = DW'(byte_cnt_q);
      end else if (err_seen_q) begin
        status      = err_code_q;
        detail_full = DW'(err_detail_q);
      end else if (at_start_q) begin
        status      = ST_EMPTY_SEGMENT;
        detail_full = DW'(seg_begin_q);
      end else if (seg_over) begin
        status      = ST_TOO_MANY_SEGMENTS;
        detail_full = DW'(seg_inc);
      end else if (seg_inc < SEG_CNT_W'(2)) begin
        status      = ST_NOT_NAMESPACED;
        detail_full = DW'(seg_inc);
      end
      byte_cnt_d   = '0;
      seg_cnt_d    = '0;
      at_start_d   = 1'b1;
      err_seen_d   = 1'b0;
      err_code_d   = ST_OK;
      err_detail_d = '0;
      seg_begin_d  = '0;
    end
  end

  assign res_o.status = status;
  assign res_o.detail = (detail_full > DETAIL_CAP) ? DETAIL_MAX : detail_full[DETAIL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= in_action_i;
      char_q   <= in_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      seg_cnt_q    <= '0;
      at_start_q   <= 1'b1;
      err_seen_q   <= 1'b0;
      err_code_q   <= ST_OK;
      err_detail_q <= '0;
      seg_begin_q  <= '0;
    end else if (advance) begin
      byte_cnt_q   <= byte_cnt_d;
      seg_cnt_q    <= seg_cnt_d;
      at_start_q   <= at_start_d;
      err_seen_q   <= err_seen_d;
      err_code_q   <= err_code_d;
      err_detail_q <= err_detail_d;
      seg_begin_q  <= seg_begin_d;
    end
  end

  `DOTID_ASSERT_RST(a_end_clears, clk_i, rst_ni, (advance && action_q == ACT_END) |=> (byte_cnt_q == '0 && at_start_q && !err_seen_q), "stream state not cleared after end")
  `DOTID_ASSERT_RST(a_count_grows, clk_i, rst_ni, (advance && action_q == ACT_BYTE) |=> (byte_cnt_q >= $past(byte_cnt_q)), "byte count went backwards")
  `DOTID_ASSERT_RST(a_err_sticky, clk_i, rst_ni, (err_seen_q && !(advance && action_q == ACT_END)) |=> (err_seen_q && $stable(err_code_q)), "first error was overwritten")
  `DOTID_ASSERT_RST(a_ok_no_err, clk_i, rst_ni, (res_valid_o && res_o.status == ST_OK) |-> (!err_seen_q && seg_inc >= SEG_CNT_W'(2)), "ok status with a latched error")

endmodule

### design/dotid_result_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one status until the output channel takes it.
// ----------------------------------------------------------------------------
module dotid_result_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  output logic               res_ready_o,
  input  dotid_pkg::result_t res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dotid_pkg::result_t out_o
);
  import dotid_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule
